[rtl/core/adc_scale_moving_average_macros.svh]
// Assertion helpers shared by the filter core.
// Each expects a clock named clk and an active-low reset named arst_n.
`ifndef ADC_SCALE_MOVING_AVERAGE_MACROS_SVH
`define ADC_SCALE_MOVING_AVERAGE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ADCSMA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ADCSMA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/adcsma_pkg.sv]
package adcsma_pkg;

	// Slots and ring depth
	localparam int SLOTS       = 8;
	localparam int MAX_TAPS    = 128;
	localparam int SLOT_W      = 3;
	localparam int COUNT_W     = 12;
	localparam int LEN_W       = 8;
	localparam int POS_W       = $clog2(MAX_TAPS);
	localparam int N_W         = $clog2(MAX_TAPS + 1);
	localparam int TAP_DEPTH   = SLOTS * MAX_TAPS;
	localparam int TAP_ADDR_W  = $clog2(TAP_DEPTH);

	// Datapath widths
	localparam int CODE_W      = 14;
	localparam int SUM_W       = CODE_W + $clog2(MAX_TAPS);
	localparam int VREF_W      = 13;
	localparam int PROD_W      = SUM_W + VREF_W;
	localparam int FRAC_SHIFT  = 8;
	localparam int NUM_W       = PROD_W + FRAC_SHIFT;
	localparam int MV_PER_V    = 1000;
	localparam int DEN_W       = $clog2(MV_PER_V * MAX_TAPS + 1);
	localparam int QUO_W       = 23;
	localparam int VOLT_W      = 24;
	localparam int DIV_CNT_W   = $clog2(QUO_W + 1);

	// Conversion constants
	localparam int BIP_SPLIT   = 2048;
	localparam int BIP_BIAS    = 4097;
	localparam int SUM_MAX     = 4354 * MAX_TAPS;

	// APB register map
	localparam int PADDR_W     = 5;
	localparam int PDATA_W     = 32;
	localparam int REG_IDX_W   = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_ENABLE   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_UNIPOLAR = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_VREF     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_FILTLEN  = 3'd4;

	localparam logic [1:0] VREF_RESET = 2'd3;

	typedef struct packed {
		logic [7:0]        enable_mask;
		logic [7:0]        unipolar_mask;
		logic [1:0]        vref_sel;
		logic signed [7:0] offset_cal;
		logic [LEN_W-1:0]  filter_length;
		logic              len_wr;
	} cfg_t;

	// Reference in millivolts
	function automatic logic [VREF_W-1:0] vref_mv(input logic [1:0] sel);
		logic [VREF_W-1:0] mv;
		case (sel)
			2'd0:    mv = VREF_W'(1200);
			2'd1:    mv = VREF_W'(2500);
			2'd2:    mv = VREF_W'(4096);
			default: mv = VREF_W'(5000);
		endcase
		return mv;
	endfunction

endpackage

[rtl/core/adcsma_ram.sv]
module adcsma_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 14,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/adcsma_regs.sv]
module adcsma_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [adcsma_pkg::PADDR_W-1:0]  paddr,
	input  logic [adcsma_pkg::PDATA_W-1:0]  pwdata,
	output logic [adcsma_pkg::PDATA_W-1:0]  prdata,
	output logic                            pready,
	output adcsma_pkg::cfg_t                cfg
);

	logic [adcsma_pkg::REG_IDX_W-1:0] idx;
	logic                             wr;

	assign pready = 1'b1;
	assign idx    = paddr[adcsma_pkg::PADDR_W-1:2];
	assign wr     = psel & penable & pwrite;

	// Register writes; a length write also flags the filter clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.enable_mask   <= '0;
			cfg.unipolar_mask <= '0;
			cfg.vref_sel      <= adcsma_pkg::VREF_RESET;
			cfg.offset_cal    <= '0;
			cfg.filter_length <= '0;
			cfg.len_wr        <= 1'b0;
		end else begin
			cfg.len_wr <= 1'b0;
			if (wr) begin
				case (idx)
					adcsma_pkg::REG_ENABLE:   cfg.enable_mask   <= pwdata[7:0];
					adcsma_pkg::REG_UNIPOLAR: cfg.unipolar_mask <= pwdata[7:0];
					adcsma_pkg::REG_VREF:     cfg.vref_sel      <= pwdata[1:0];
					adcsma_pkg::REG_OFFSET:   cfg.offset_cal    <= $signed(pwdata[7:0]);
					adcsma_pkg::REG_FILTLEN: begin
						cfg.filter_length <= pwdata[adcsma_pkg::LEN_W-1:0];
						cfg.len_wr        <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// Read-back
	always_comb begin
		case (idx)
			adcsma_pkg::REG_ENABLE:   prdata = adcsma_pkg::PDATA_W'(cfg.enable_mask);
			adcsma_pkg::REG_UNIPOLAR: prdata = adcsma_pkg::PDATA_W'(cfg.unipolar_mask);
			adcsma_pkg::REG_VREF:     prdata = adcsma_pkg::PDATA_W'(cfg.vref_sel);
			adcsma_pkg::REG_OFFSET:   prdata = adcsma_pkg::PDATA_W'($unsigned(cfg.offset_cal));
			adcsma_pkg::REG_FILTLEN:  prdata = adcsma_pkg::PDATA_W'(cfg.filter_length);
			default:                  prdata = '0;
		endcase
	end

endmodule

[rtl/core/adcsma_div.sv]
module adcsma_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [adcsma_pkg::NUM_W-1:0]    dividend,
	input  logic [adcsma_pkg::DEN_W-1:0]    divisor,
	output logic                            done,
	output logic [adcsma_pkg::QUO_W-1:0]    quotient
);

	localparam int QW = adcsma_pkg::QUO_W;
	localparam int DW = adcsma_pkg::DEN_W;

	logic [adcsma_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                             done_q;
	logic [DW-1:0]                    rem_q;
	logic [QW-1:0]                    lo_q;
	logic [DW-1:0]                    den_q;
	logic [DW:0]                      trial;
	logic                             ge;

	// Restoring step: one quotient bit per cycle; the top of the
	// dividend is already below the divisor, so QW steps suffice
	assign trial    = {rem_q, lo_q[QW-1]};
	assign ge       = trial >= {1'b0, den_q};
	assign done     = done_q;
	assign quotient = lo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= adcsma_pkg::DIV_CNT_W'(QW);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == adcsma_pkg::DIV_CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DW'(dividend[adcsma_pkg::NUM_W-1:QW]);
			lo_q  <= dividend[QW-1:0];
			den_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? DW'(trial - {1'b0, den_q}) : DW'(trial);
			lo_q  <= {lo_q[QW-2:0], ge};
		end
	end

endmodule

[rtl/core/adc_scale_moving_average.sv]
// Channel   | Direction | Handshake          | Contents
// s_*       | in        | tvalid/tready      | converter reply: slot, count, ok flag
// m_*       | out       | tvalid/tready      | slot and Q20 voltage
// APB       | in/out    | psel/penable       | five configuration registers
//
// A good reply with filtering on passes through tap read-modify-write,
// multiply, divider load, the 23 divider steps, done and the output
// register; with filtering off the tap read-modify-write is skipped. The
// output stage waits while an earlier word is still unaccepted. The next
// reply is taken once the sequencer is back in idle. A dropped reply is
// consumed without leaving idle. One reply is in flight at a time.
// After reset, and after each filter_length write, a clearing pass over
// all 1024 tap entries zeroes the tap memory; no reply is taken meanwhile.
// A finished word waits in the output register while the next reply runs.
`include "adc_scale_moving_average_macros.svh"

module adc_scale_moving_average (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [15:0]                    s_tdata,  // slot[2:0], raw_count[14:3], pad
	input  logic [0:0]                     s_tuser,  // reply_ok[0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [31:0]                    m_tdata,  // out_slot[2:0], volts_q20[26:3], pad
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [adcsma_pkg::PADDR_W-1:0] paddr,
	input  logic [adcsma_pkg::PDATA_W-1:0] pwdata,
	output logic [adcsma_pkg::PDATA_W-1:0] prdata,
	output logic                           pready
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SUM,
		S_MUL,
		S_DIV,
		S_OUT
	} state_t;

	localparam int CW   = adcsma_pkg::CODE_W;
	localparam int SW   = adcsma_pkg::SUM_W;
	localparam int AW   = adcsma_pkg::TAP_ADDR_W;
	localparam int SMAX = adcsma_pkg::SUM_MAX;

	adcsma_pkg::cfg_t cfg;

	state_t state_q;
	logic [AW-1:0]                    clr_cnt_q;
	logic [adcsma_pkg::POS_W-1:0]     pos_q [adcsma_pkg::SLOTS];
	logic signed [SW-1:0]             sum_q [adcsma_pkg::SLOTS];
	logic                             div_start_q;

	// Datapath registers
	logic [adcsma_pkg::SLOT_W-1:0]    slot_q;
	logic signed [CW-1:0]             code_q;
	logic [AW-1:0]                    addr_q;
	logic [adcsma_pkg::N_W-1:0]       pos_cur_q;
	logic                             filt_q;
	logic signed [SW-1:0]             total_q;
	logic                             neg_q;
	logic [adcsma_pkg::PROD_W-1:0]    prod_q;
	logic [adcsma_pkg::DEN_W-1:0]     den_q;

	// Input word fields
	logic [adcsma_pkg::SLOT_W-1:0]    in_slot;
	logic [adcsma_pkg::COUNT_W-1:0]   in_count;
	logic                             in_ok;
	logic                             accept;
	logic                             item_good;

	logic [adcsma_pkg::N_W-1:0]       len_eff;
	logic                             filt_on;
	logic [adcsma_pkg::N_W-1:0]       pos_eff;
	logic [adcsma_pkg::N_W-1:0]       pos_inc;
	logic [adcsma_pkg::N_W-1:0]       pos_nxt;
	logic signed [CW:0]               bip_half;
	logic signed [CW-1:0]             code_new;
	logic signed [SW-1:0]             sum_new;
	logic [SW-1:0]                    mag;
	logic [adcsma_pkg::NUM_W-1:0]     dividend;
	logic                             div_done;
	logic [adcsma_pkg::QUO_W-1:0]     quotient;
	logic [adcsma_pkg::VOLT_W-1:0]    volts;

	logic                             tap_we;
	logic [AW-1:0]                    tap_waddr;
	logic [CW-1:0]                    tap_wdata;
	logic [AW-1:0]                    tap_raddr;
	logic [CW-1:0]                    tap_rdata;

	adcsma_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	adcsma_ram #(
		.DEPTH (adcsma_pkg::TAP_DEPTH),
		.WIDTH (CW),
		.AW    (AW)
	) u_taps (
		.clk   (clk),
		.we    (tap_we),
		.waddr (tap_waddr),
		.wdata (tap_wdata),
		.raddr (tap_raddr),
		.rdata (tap_rdata)
	);

	adcsma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (dividend),
		.divisor  (den_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign in_slot   = s_tdata[2:0];
	assign in_count  = s_tdata[14:3];
	assign in_ok     = s_tuser[0];
	// No reply is taken in the cycle that starts the clearing pass
	assign s_tready  = (state_q == S_IDLE) && !cfg.len_wr;
	assign accept    = s_tvalid & s_tready;
	assign item_good = in_ok && (int'(in_slot) < adcsma_pkg::SLOTS)
		&& cfg.enable_mask[in_slot];

	// Effective length, clamped to the ring depth
	assign len_eff = (int'(cfg.filter_length) > adcsma_pkg::MAX_TAPS)
		? adcsma_pkg::N_W'(adcsma_pkg::MAX_TAPS)
		: adcsma_pkg::N_W'(cfg.filter_length);
	assign filt_on = len_eff > adcsma_pkg::N_W'(1);

	// Tap position for this slot, wrapped if the length shrank
	assign pos_eff = (adcsma_pkg::N_W'(pos_q[in_slot]) >= len_eff)
		? '0 : adcsma_pkg::N_W'(pos_q[in_slot]);
	assign pos_inc = pos_cur_q + 1'b1;
	assign pos_nxt = (pos_inc >= len_eff) ? '0 : pos_inc;

	// Count to signed code
	always_comb begin
		if (in_count >= adcsma_pkg::COUNT_W'(adcsma_pkg::BIP_SPLIT)) begin
			bip_half = $signed({3'b000, in_count}) - (CW + 1)'(adcsma_pkg::BIP_BIAS)
				+ (CW + 1)'(cfg.offset_cal);
		end else begin
			bip_half = $signed({3'b000, in_count}) + (CW + 1)'(cfg.offset_cal);
		end
		if (cfg.unipolar_mask[in_slot]) begin
			code_new = $signed({2'b00, in_count});
		end else begin
			code_new = $signed({bip_half[CW-2:0], 1'b0});
		end
	end

	// Running sum update with the displaced tap
	assign sum_new = sum_q[slot_q] + SW'(code_q) - SW'($signed(tap_rdata));
	assign mag     = total_q[SW-1] ? SW'(-total_q) : SW'(total_q);

	// Scaled numerator with half the divisor added for rounding
	assign dividend = {prod_q, adcsma_pkg::FRAC_SHIFT'(0)}
		+ adcsma_pkg::NUM_W'(den_q >> 1);
	assign volts = neg_q ? -adcsma_pkg::VOLT_W'(quotient)
		: adcsma_pkg::VOLT_W'(quotient);

	// Tap memory ports: clearing sweep or write-back of the new code
	assign tap_raddr = AW'(in_slot * adcsma_pkg::MAX_TAPS) + AW'(pos_eff);
	always_comb begin
		case (state_q)
			S_CLEAR: begin
				tap_we    = 1'b1;
				tap_waddr = clr_cnt_q;
				tap_wdata = '0;
			end
			S_SUM: begin
				tap_we    = 1'b1;
				tap_waddr = addr_q;
				tap_wdata = code_q;
			end
			default: begin
				tap_we    = 1'b0;
				tap_waddr = addr_q;
				tap_wdata = code_q;
			end
		endcase
	end

	// Sequencer, per-slot ring state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			div_start_q <= 1'b0;
			m_tvalid    <= 1'b0;
			m_tdata     <= '0;
			for (int i = 0; i < adcsma_pkg::SLOTS; i++) begin
				pos_q[i] <= '0;
				sum_q[i] <= '0;
			end
		end else begin
			div_start_q <= 1'b0;
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == AW'(adcsma_pkg::TAP_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept && item_good) begin
						state_q <= filt_on ? S_SUM : S_MUL;
					end
				end
				S_SUM: begin
					sum_q[slot_q] <= sum_new;
					pos_q[slot_q] <= adcsma_pkg::POS_W'(pos_nxt);
					state_q       <= S_MUL;
				end
				S_MUL: begin
					div_start_q <= 1'b1;
					state_q     <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {5'b00000, volts, slot_q};
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// A new length restarts every ring from zero
			if (cfg.len_wr) begin
				state_q   <= S_CLEAR;
				clr_cnt_q <= '0;
				for (int i = 0; i < adcsma_pkg::SLOTS; i++) begin
					pos_q[i] <= '0;
					sum_q[i] <= '0;
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q    <= in_slot;
			code_q    <= code_new;
			addr_q    <= tap_raddr;
			pos_cur_q <= pos_eff;
			filt_q    <= filt_on;
			total_q   <= SW'(code_new);
		end
		if (state_q == S_SUM) begin
			total_q <= sum_new;
		end
		if (state_q == S_MUL) begin
			neg_q  <= total_q[SW-1];
			prod_q <= adcsma_pkg::PROD_W'(mag)
				* adcsma_pkg::PROD_W'(adcsma_pkg::vref_mv(cfg.vref_sel));
			den_q  <= (filt_q ? adcsma_pkg::DEN_W'(len_eff) : adcsma_pkg::DEN_W'(1))
				* adcsma_pkg::DEN_W'(adcsma_pkg::MV_PER_V);
		end
	end

	`ADCSMA_ASSERT_IMP(a_tap_wb, state_q == S_SUM, tap_we && tap_waddr == $past(tap_raddr), "tap wb")
	`ADCSMA_ASSERT_NXT(a_drop_stays_idle, accept && !in_ok, state_q == S_IDLE, "dropped reply")
	`ADCSMA_ASSERT_IMP(a_sum_bound, state_q == S_MUL, total_q <= SMAX && total_q >= -SMAX, "sum range")
	`ADCSMA_ASSERT_IMP(a_div_done_state, div_done, state_q == S_DIV, "divider done out of phase")

endmodule
